// ----- design/knapsack_01_selector_defines.svh -----
// assertion macros shared by the knapsack selector rtl
`ifndef KNAPSACK_01_SELECTOR_DEFINES_SVH
`define KNAPSACK_01_SELECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KNAP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define KNAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/knap_pkg.sv -----
// shared constants and types for the knapsack selector
package knap_pkg;

   localparam int DEF_MAX_ITEMS    = 64;
   localparam int DEF_MAX_CAPACITY = 255;

   localparam int ITEM_W  = 8;
   localparam int TOTAL_W = 14;
   localparam int INDEX_W = 6;

   localparam logic [ITEM_W-1:0]  DEFAULT_CAPACITY = 8'd16;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX        = 14'h3fff;

   typedef struct packed {
      logic              start;
      logic              first;
      logic [ITEM_W-1:0] weight;
      logic [ITEM_W-1:0] value;
   } knap_row_cmd_type;

endpackage

// ----- design/knap_row.sv -----
// best-total row memory and the per-item descending update pass
module knap_row #(
   parameter int MAX_CAPACITY = knap_pkg::DEF_MAX_CAPACITY,
   localparam int CW = $clog2(MAX_CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  knap_pkg::knap_row_cmd_type       row_cmd,
   input  logic [CW-1:0]                    total_addr,
   output logic [knap_pkg::TOTAL_W-1:0]     total_data,
   output logic                             take_we,
   output logic [CW-1:0]                    take_budget,
   output logic                             take_bit,
   output logic                             pass_done
);
   import knap_pkg::*;

   localparam int SW = ((CW > ITEM_W) ? CW : ITEM_W) + 1;
   localparam int SUM_W = TOTAL_W + 1;
   localparam logic [CW-1:0] TOP_BUDGET = CW'(MAX_CAPACITY);

   logic [TOTAL_W-1:0] row_mem [MAX_CAPACITY + 1];

   logic              busy_ff;
   logic [CW-1:0]     b_ff;
   logic              first_ff;
   logic [ITEM_W-1:0] wt_ff;
   logic [ITEM_W-1:0] val_ff;
   logic              s1_valid_ff;
   logic [CW-1:0]     s1_b_ff;
   logic              s1_fit_ff;
   logic [TOTAL_W-1:0] keep_rd_ff;
   logic [TOTAL_W-1:0] low_rd_ff;

   logic [SW-1:0]      diff;
   logic               fit;
   logic [CW-1:0]      low_addr;
   logic [CW-1:0]      rd_addr;
   logic [TOTAL_W-1:0] keep_val;
   logic [TOTAL_W-1:0] low_val;
   logic [SUM_W-1:0]   with_sum;
   logic               take;
   logic [TOTAL_W-1:0] new_val;

   assign diff     = SW'(b_ff) - SW'(wt_ff);
   assign fit      = !diff[SW-1];
   assign low_addr = fit ? diff[CW-1:0] : '0;
   assign rd_addr  = busy_ff ? b_ff : total_addr;

   // first item of a set sees an all-zero row, so no clearing pass is needed
   assign keep_val = first_ff ? '0 : keep_rd_ff;
   assign low_val  = first_ff ? '0 : low_rd_ff;
   assign with_sum = SUM_W'(low_val) + SUM_W'(val_ff);
   assign take     = s1_fit_ff && (with_sum > SUM_W'(keep_val));
   assign new_val  = !take ? keep_val :
                     (with_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : with_sum[TOTAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (row_cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && b_ff == '0) begin
            busy_ff <= 1'b0;
         end
         s1_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (row_cmd.start) begin
         b_ff     <= TOP_BUDGET;
         first_ff <= row_cmd.first;
         wt_ff    <= row_cmd.weight;
         val_ff   <= row_cmd.value;
      end else if (busy_ff) begin
         b_ff <= b_ff - CW'(1);
      end
      s1_b_ff   <= b_ff;
      s1_fit_ff <= fit;
   end

   // descending walk: a write at budget b never meets a later read, all below b
   always_ff @(posedge clock) begin
      keep_rd_ff <= row_mem[rd_addr];
      low_rd_ff  <= row_mem[low_addr];
      if (s1_valid_ff) begin
         row_mem[s1_b_ff] <= new_val;
      end
   end

   assign total_data  = keep_rd_ff;
   assign take_we     = s1_valid_ff;
   assign take_budget = s1_b_ff;
   assign take_bit    = take;
   assign pass_done   = s1_valid_ff && (s1_b_ff == '0);

endmodule

// ----- design/knap_store.sv -----
// take-bit, weight and chosen-bit memories for backtracking and readout
module knap_store #(
   parameter int MAX_ITEMS    = knap_pkg::DEF_MAX_ITEMS,
   parameter int MAX_CAPACITY = knap_pkg::DEF_MAX_CAPACITY,
   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
   localparam int CW = $clog2(MAX_CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        weight_we,
   input  logic [IW-1:0]               weight_addr,
   input  logic [knap_pkg::ITEM_W-1:0] weight_data,
   input  logic                        take_we,
   input  logic [IW-1:0]               take_item,
   input  logic [CW-1:0]               take_budget,
   input  logic                        take_bit,
   input  logic [IW-1:0]               bt_item,
   input  logic [CW-1:0]               bt_budget,
   output logic                        take_rd,
   output logic [knap_pkg::ITEM_W-1:0] weight_rd,
   input  logic                        chosen_we,
   input  logic [IW-1:0]               chosen_waddr,
   input  logic                        chosen_wdata,
   input  logic [IW-1:0]               chosen_raddr,
   output logic                        chosen_rd
);
   import knap_pkg::*;

   logic [ITEM_W-1:0] weight_mem [MAX_ITEMS];
   logic              take_mem   [MAX_ITEMS << CW];
   logic              chosen_mem [MAX_ITEMS];

   logic              take_rd_ff;
   logic [ITEM_W-1:0] weight_rd_ff;
   logic              chosen_rd_ff;

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[weight_addr] <= weight_data;
      end
      weight_rd_ff <= weight_mem[bt_item];
   end

   always_ff @(posedge clock) begin
      if (take_we) begin
         take_mem[{take_item, take_budget}] <= take_bit;
      end
      take_rd_ff <= take_mem[{bt_item, bt_budget}];
   end

   // every stored item gets its flag written during backtrack, so no clearing
   always_ff @(posedge clock) begin
      if (chosen_we) begin
         chosen_mem[chosen_waddr] <= chosen_wdata;
      end
      chosen_rd_ff <= chosen_mem[chosen_raddr];
   end

   assign take_rd   = take_rd_ff;
   assign weight_rd = weight_rd_ff;
   assign chosen_rd = chosen_rd_ff;

endmodule

// ----- design/knapsack_01_selector.sv -----
// 0/1 knapsack selector: loads an item set, solves it, streams one beat per item
//
// Input channel req_*: one item per beat (weight, value, last flag). Each stored
// item runs one update pass over the best-total row memory, one budget per
// cycle from MAX_CAPACITY down to 0, so the next beat is taken only once the
// pass is done; req_stall stays high during the pass.
// Items beyond MAX_ITEMS are dropped at once and flag overflow on the results.
// A beat with last_item set ends the set: the best total is read (ST_TOT_RD,
// ST_TOT_LD), the take-bit memory is walked back from the capacity, item by item
// (ST_BT_RD, ST_BT_UPD), then one result beat per stored item goes out on rsp_*
// in load order, each read from the chosen-bit memory before the output register.
// rsp_stall holds the output register and pauses the readout; the next set is
// loaded once the final result beat is in the output register.
// csr_write_enable writes the capacity register (0 selects 16, values above
// MAX_CAPACITY saturate); write it only while the block is idle.
// Reset (synchronous, active high) empties the set, drops any pending result
// and sets the capacity to 16; no memory clearing pass is needed.
module knapsack_01_selector #(
   parameter int MAX_ITEMS    = knap_pkg::DEF_MAX_ITEMS,
   parameter int MAX_CAPACITY = knap_pkg::DEF_MAX_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [knap_pkg::ITEM_W-1:0]  req_item_weight,
   input  logic [knap_pkg::ITEM_W-1:0]  req_item_value,
   input  logic                         req_last_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [knap_pkg::INDEX_W-1:0] rsp_item_index,
   output logic                         rsp_chosen,
   output logic [knap_pkg::TOTAL_W-1:0] rsp_best_total,
   output logic                         rsp_overflow,
   output logic                         rsp_last_result,
   input  logic                         csr_write_enable,
   input  logic [knap_pkg::ITEM_W-1:0]  csr_write_data
);
   import knap_pkg::*;

   `include "knapsack_01_selector_defines.svh"

   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int NW = $clog2(MAX_ITEMS + 1);
   localparam int CW = $clog2(MAX_CAPACITY + 1);
   localparam int SW = ((CW > ITEM_W) ? CW : ITEM_W) + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PASS   = 3'd1;
   localparam logic [2:0] ST_TOT_RD = 3'd2;
   localparam logic [2:0] ST_TOT_LD = 3'd3;
   localparam logic [2:0] ST_BT_RD  = 3'd4;
   localparam logic [2:0] ST_BT_UPD = 3'd5;
   localparam logic [2:0] ST_EM_RD  = 3'd6;
   localparam logic [2:0] ST_EM_LD  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [ITEM_W-1:0]  capacity_ff;
   logic [NW-1:0]      count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic               last_ff, last_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [IW-1:0]      bt_i_ff, bt_i_in;
   logic [IW-1:0]      em_k_ff, em_k_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_chosen_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_overflow_ff;
   logic               rsp_last_ff;

   knap_row_cmd_type   row_cmd;
   logic [TOTAL_W-1:0] total_data;
   logic               take_we;
   logic [CW-1:0]      take_budget;
   logic               take_bit;
   logic               pass_done;
   logic               weight_we;
   logic               take_rd;
   logic [ITEM_W-1:0]  weight_rd;
   logic               chosen_we;
   logic               chosen_rd;

   logic               accept;
   logic               rsp_free;
   logic               out_load;
   logic [ITEM_W-1:0]  cap_raw;
   logic [CW-1:0]      cap_eff;
   logic [NW-1:0]      last_idx;
   logic               em_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign cap_raw  = (capacity_ff == '0) ? DEFAULT_CAPACITY : capacity_ff;
   assign cap_eff  = (SW'(cap_raw) > SW'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY) : CW'(cap_raw);
   assign last_idx = count_ff - NW'(1);
   assign em_last  = (em_k_ff == last_idx[IW-1:0]);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      last_in        = last_ff;
      rem_in         = rem_ff;
      bt_i_in        = bt_i_ff;
      em_k_in        = em_k_ff;
      total_in       = total_ff;
      row_cmd.start  = 1'b0;
      row_cmd.first  = (count_ff == '0);
      row_cmd.weight = req_item_weight;
      row_cmd.value  = req_item_value;
      weight_we      = 1'b0;
      chosen_we      = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last_item;
               if (count_ff < NW'(MAX_ITEMS)) begin
                  row_cmd.start = 1'b1;
                  weight_we     = 1'b1;
                  state_in      = ST_PASS;
               end else begin
                  // store full: item is dropped but its last mark still counts
                  dropped_in = 1'b1;
                  if (req_last_item) begin
                     state_in = ST_TOT_RD;
                  end
               end
            end
         end
         ST_PASS: begin
            if (pass_done) begin
               count_in = count_ff + NW'(1);
               state_in = last_ff ? ST_TOT_RD : ST_IDLE;
            end
         end
         ST_TOT_RD: begin
            rem_in   = cap_eff;
            bt_i_in  = last_idx[IW-1:0];
            state_in = ST_TOT_LD;
         end
         ST_TOT_LD: begin
            total_in = total_data;
            state_in = ST_BT_RD;
         end
         ST_BT_RD: begin
            state_in = ST_BT_UPD;
         end
         ST_BT_UPD: begin
            chosen_we = 1'b1;
            if (take_rd) begin
               rem_in = CW'(SW'(rem_ff) - SW'(weight_rd));
            end
            if (bt_i_ff == '0) begin
               em_k_in  = '0;
               state_in = ST_EM_RD;
            end else begin
               bt_i_in  = bt_i_ff - IW'(1);
               state_in = ST_BT_RD;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            if (rsp_free) begin
               out_load = 1'b1;
               if (em_last) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  em_k_in  = em_k_ff + IW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= DEFAULT_CAPACITY;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      rem_ff   <= rem_in;
      bt_i_ff  <= bt_i_in;
      em_k_ff  <= em_k_in;
      total_ff <= total_in;
      if (out_load) begin
         rsp_index_ff    <= INDEX_W'(em_k_ff);
         rsp_chosen_ff   <= chosen_rd;
         rsp_total_ff    <= total_ff;
         rsp_overflow_ff <= dropped_ff;
         rsp_last_ff     <= em_last;
      end
   end

   knap_row #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_row (
      .clock       (clock),
      .reset       (reset),
      .row_cmd     (row_cmd),
      .total_addr  (cap_eff),
      .total_data  (total_data),
      .take_we     (take_we),
      .take_budget (take_budget),
      .take_bit    (take_bit),
      .pass_done   (pass_done)
   );

   knap_store #(
      .MAX_ITEMS    (MAX_ITEMS),
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_store (
      .clock        (clock),
      .weight_we    (weight_we),
      .weight_addr  (count_ff[IW-1:0]),
      .weight_data  (req_item_weight),
      .take_we      (take_we),
      .take_item    (count_ff[IW-1:0]),
      .take_budget  (take_budget),
      .take_bit     (take_bit),
      .bt_item      (bt_i_ff),
      .bt_budget    (rem_ff),
      .take_rd      (take_rd),
      .weight_rd    (weight_rd),
      .chosen_we    (chosen_we),
      .chosen_waddr (bt_i_ff),
      .chosen_wdata (take_rd),
      .chosen_raddr (em_k_ff),
      .chosen_rd    (chosen_rd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_index  = rsp_index_ff;
   assign rsp_chosen      = rsp_chosen_ff;
   assign rsp_best_total  = rsp_total_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_last_result = rsp_last_ff;

   `KNAP_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= NW'(MAX_ITEMS),
                    "item count past store size")
   `KNAP_ASSERT_NOW(a_pass_in_state, pass_done, state_ff == ST_PASS,
                    "row pass ended outside load")
   `KNAP_ASSERT_NOW(a_bt_no_underflow, (state_ff == ST_BT_UPD) && take_rd,
                    SW'(weight_rd) <= SW'(rem_ff), "backtrack weight exceeds remaining budget")
   `KNAP_ASSERT_NEXT(a_set_cleared, out_load && em_last,
                     (count_ff == '0) && !dropped_ff && (state_ff == ST_IDLE),
                     "set not cleared after final beat")

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the knapsack_01_selector item solver
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import knap_pkg::*;

   typedef struct packed {
      logic [ITEM_W-1:0] weight;
      logic [ITEM_W-1:0] value;
      logic              last;
   } knap_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               chosen;
      logic [TOTAL_W-1:0] total;
      logic               overflow;
      logic               last;
   } selection_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ITEM_W-1:0]   req_item_weight = '0;
   logic [ITEM_W-1:0]   req_item_value = '0;
   logic                req_last_item = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_item_index;
   logic                rsp_chosen;
   logic [TOTAL_W-1:0]  rsp_best_total;
   logic                rsp_overflow;
   logic                rsp_last_result;
   logic                csr_write_enable = 1'b0;
   logic [ITEM_W-1:0]   csr_write_data = '0;

   // solver state mirrored in the bench
   logic [TOTAL_W-1:0]  row_best [0:DEF_MAX_CAPACITY];
   bit                  take_tbl [0:DEF_MAX_ITEMS-1][0:DEF_MAX_CAPACITY];
   logic [ITEM_W-1:0]   stored_wt [0:DEF_MAX_ITEMS-1];
   bit                  chosen_flags [0:DEF_MAX_ITEMS-1];
   int                  stored_count = 0;
   bit                  dropped = 1'b0;
   logic [ITEM_W-1:0]   capacity_setting = DEFAULT_CAPACITY;

   knap_item_type       item_queue [$];
   selection_type       expected_selections [$];
   knap_item_type       cur_item;
   selection_type       got_sel;
   int                  errors = 0;
   int                  send_wait = 0;
   int                  send_calm = 0;
   int                  hold_left = 0;
   int                  recv_calm = 0;
   int                  results_seen = 0;
   bit                  long_hold_done = 1'b0;
   bit                  long_kick = 1'b0;
   bit                  long_hold_kick = 1'b0;
   int                  long_hold_left = 0;
   logic                next_valid;
   int                  random_items = 0;

   knapsack_01_selector u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item_weight  (req_item_weight),
      .req_item_value   (req_item_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_index   (rsp_item_index),
      .rsp_chosen       (rsp_chosen),
      .rsp_best_total   (rsp_best_total),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   initial begin
      foreach (row_best[b]) row_best[b] = '0;
      foreach (chosen_flags[i]) chosen_flags[i] = 1'b0;
   end

   // one update pass over the row per stored item; a last beat closes the set
   task automatic absorb_item(input logic [ITEM_W-1:0] wt, input logic [ITEM_W-1:0] val,
                              input logic last);
      int b;
      int sum;
      int cap;
      int rem;
      int k;
      selection_type sel;
      if (stored_count < DEF_MAX_ITEMS) begin
         stored_wt[stored_count] = wt;
         for (b = DEF_MAX_CAPACITY; b >= 0; b--) begin
            take_tbl[stored_count][b] = 1'b0;
            if (int'(wt) <= b) begin
               sum = int'(row_best[b - int'(wt)]) + int'(val);
               if (sum > int'(row_best[b])) begin
                  take_tbl[stored_count][b] = 1'b1;
                  row_best[b] = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
               end
            end
         end
         stored_count++;
      end else begin
         dropped = 1'b1;
      end
      if (last) begin
         cap = (capacity_setting == 0) ? int'(DEFAULT_CAPACITY) : int'(capacity_setting);
         if (cap > DEF_MAX_CAPACITY) cap = DEF_MAX_CAPACITY;
         rem = cap;
         for (k = stored_count - 1; k >= 0; k--) begin
            if (take_tbl[k][rem]) begin
               chosen_flags[k] = 1'b1;
               rem = rem - int'(stored_wt[k]);
            end
         end
         for (k = 0; k < stored_count; k++) begin
            sel.index    = k[INDEX_W-1:0];
            sel.chosen   = chosen_flags[k];
            sel.total    = row_best[cap];
            sel.overflow = dropped;
            sel.last     = (k == stored_count - 1);
            expected_selections = {expected_selections, sel};
         end
         foreach (row_best[b2]) row_best[b2] = '0;
         foreach (chosen_flags[i]) chosen_flags[i] = 1'b0;
         stored_count = 0;
         dropped = 1'b0;
      end
   endtask

   // idle cycles before the next beat, with runs of back-to-back beats
   task automatic pick_gap(inout int calm, output int gap);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(5, 20);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 5);
      end
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            absorb_item(req_item_weight, req_item_value, req_last_item);
            next_valid = 1'b0;
            pick_gap(send_calm, send_wait);
         end
         if (!next_valid) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (item_queue.size() != 0) begin
               cur_item = item_queue.pop_front();
               req_item_weight <= cur_item.weight;
               req_item_value  <= cur_item.value;
               req_last_item   <= cur_item.last;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         long_hold_kick <= 1'b0;
         hold_left = 0;
      end else begin
         long_kick = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            if (expected_selections.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, index %0d",
                        $time, rsp_item_index);
               errors++;
            end else begin
               got_sel = expected_selections.pop_front();
               check_field("item_index", int'(got_sel.index), int'(rsp_item_index));
               check_field("chosen", int'(got_sel.chosen), int'(rsp_chosen));
               check_field("best_total", int'(got_sel.total), int'(rsp_best_total));
               check_field("overflow", int'(got_sel.overflow), int'(rsp_overflow));
               check_field("last_result", int'(got_sel.last), int'(rsp_last_result));
            end
            results_seen++;
            pick_gap(recv_calm, hold_left);
            // long hold mid-readout while new items keep coming
            if (!long_hold_done && results_seen > 30 && rsp_item_index == 0 &&
                expected_selections.size() > 3 && item_queue.size() != 0) begin
               long_kick = 1'b1;
               long_hold_done = 1'b1;
            end
         end
         long_hold_kick <= long_kick;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= long_kick || long_hold_kick || (long_hold_left > 0);
         end
      end
   end

   // long receiver hold counter
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
      end else if (long_hold_kick) begin
         long_hold_left <= 1200;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   task automatic push_item(input int wt, input int val, input bit last);
      knap_item_type it;
      it.weight = wt[ITEM_W-1:0];
      it.value  = val[ITEM_W-1:0];
      it.last   = last;
      item_queue = {item_queue, it};
   endtask

   task automatic queue_random_set(input int n);
      int cap;
      int i;
      int wt;
      cap = (capacity_setting == 0) ? int'(DEFAULT_CAPACITY) : int'(capacity_setting);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) wt = $urandom_range(0, 255);
         else wt = $urandom_range(0, cap);
         push_item(wt, $urandom_range(0, 255), i == n - 1);
         random_items++;
      end
   endtask

   task automatic queue_small_sets(input int count);
      int target;
      target = random_items + count;
      while (random_items < target) begin
         if ($urandom_range(0, 4) == 0) queue_random_set($urandom_range(1, 20));
         else queue_random_set($urandom_range(1, 8));
      end
   endtask

   task automatic wait_idle;
      while (item_queue.size() != 0 || req_valid || expected_selections.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [ITEM_W-1:0] cap);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      capacity_setting = cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // default capacity: zero weights, oversized weight, exact fit
      push_item(0, 0, 0);
      push_item(0, 200, 0);
      push_item(255, 255, 0);
      push_item(16, 100, 0);
      push_item(5, 30, 0);
      push_item(11, 90, 1);
      push_item(16, 1, 1);
      push_item(17, 255, 1);
      // equal alternatives, later item must strictly beat to be taken
      push_item(4, 10, 0);
      push_item(4, 10, 0);
      push_item(8, 20, 1);
      wait_idle();

      set_capacity(8'd0);
      push_item(16, 5, 0);
      push_item(8, 3, 0);
      push_item(8, 3, 1);
      wait_idle();

      set_capacity(8'd255);
      push_item(255, 255, 0);
      push_item(0, 255, 0);
      push_item(128, 1, 1);
      wait_idle();

      set_capacity(8'd1);
      push_item(1, 255, 0);
      push_item(0, 0, 0);
      push_item(2, 7, 1);
      wait_idle();

      set_capacity(ITEM_W'($urandom_range(2, 254)));
      queue_small_sets(25);
      wait_idle();

      // full store, every index used
      set_capacity(8'd255);
      queue_random_set(DEF_MAX_ITEMS);
      wait_idle();

      set_capacity(8'd200);
      queue_small_sets(20);
      wait_idle();

      // store overflow: the dropped beats carry the last mark
      set_capacity(8'd40);
      queue_random_set(DEF_MAX_ITEMS + 2);
      queue_small_sets(12);
      wait_idle();

      set_capacity(8'd0);
      queue_small_sets(15);
      wait_idle();

      set_capacity(ITEM_W'($urandom_range(1, 255)));
      while (random_items < 200) queue_random_set($urandom_range(1, 8));
      wait_idle();

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
